/* rtl/aes_block_cipher_unit_macros.svh */
// Assertion macros shared by the cipher unit RTL.
`ifndef AES_BLOCK_CIPHER_UNIT_MACROS_SVH
`define AES_BLOCK_CIPHER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AES_ASSERT_IMPLIES(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define AES_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

/* rtl/aes_bcu_pkg.sv */
// Types, tables and byte-level helpers for the AES cipher unit.
`timescale 1ns / 1ps
package aes_bcu_pkg;

   localparam int BLOCK_BYTES = 16;
   localparam int NK_TO_NR    = 6;
   localparam int MAX_ROUNDS  = 14;
   localparam int RK_WORDS    = 4 * (MAX_ROUNDS + 1);

   localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
   localparam logic [2:0] REG_KEY_WORD0  = 3'd1;
   localparam logic [2:0] REG_KEY_WORD1  = 3'd2;
   localparam logic [2:0] REG_KEY_WORD2  = 3'd3;
   localparam logic [2:0] REG_KEY_WORD3  = 3'd4;

   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   typedef struct packed {
      logic        command;
      logic [63:0] block_high;
      logic [63:0] block_low;
   } req_type;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } rsp_type;

   typedef struct packed {
      logic dec;
      logic active;
      logic mix_en;
   } round_ctl_type;

   // Byte 0 sits in the top byte.
   localparam logic [2047:0] SBOX_TABLE = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16};

   localparam logic [2047:0] INV_SBOX_TABLE = {
      128'h52096ad53036a538bf40a39e81f3d7fb, 128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e, 128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692, 128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506, 128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673, 128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b, 128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f, 128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961, 128'h172b047eba77d626e169146355210c7d};

   function automatic logic [7:0] sub_byte(input logic [7:0] x);
      logic [10:0] base;
      begin
         base = {~x, 3'b000};
         return SBOX_TABLE[base +: 8];
      end
   endfunction

   function automatic logic [7:0] inv_sub_byte(input logic [7:0] x);
      logic [10:0] base;
      begin
         base = {~x, 3'b000};
         return INV_SBOX_TABLE[base +: 8];
      end
   endfunction

   function automatic logic [31:0] sub_key_word(input logic [31:0] w);
      return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [127:0] sub_state(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      begin
         for (int i = 0; i < BLOCK_BYTES; i++)
            t[127 - 8 * i -: 8] = inv ? inv_sub_byte(s[127 - 8 * i -: 8])
                                      : sub_byte(s[127 - 8 * i -: 8]);
         return t;
      end
   endfunction

   // byte c*4+r holds row r of column c
   function automatic logic [127:0] row_shift(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[127 - 8 * (c * 4 + r) -: 8] = inv ? s[127 - 8 * (((c - r) & 3) * 4 + r) -: 8]
                                                   : s[127 - 8 * (((c + r) & 3) * 4 + r) -: 8];
         return t;
      end
   endfunction

   function automatic logic [31:0] mix_column(input logic [31:0] col, input logic inv);
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m3 [4];
      logic [7:0] m9 [4];
      logic [7:0] mb [4];
      logic [7:0] md [4];
      logic [7:0] me [4];
      logic [31:0] o;
      begin
         for (int k = 0; k < 4; k++) begin
            a[k]  = col[31 - 8 * k -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m3[k] = x2[k] ^ a[k];
            m9[k] = x8[k] ^ a[k];
            mb[k] = x8[k] ^ x2[k] ^ a[k];
            md[k] = x8[k] ^ x4[k] ^ a[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
         end
         if (inv) begin
            o = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                 m9[0] ^ me[1] ^ mb[2] ^ md[3],
                 md[0] ^ m9[1] ^ me[2] ^ mb[3],
                 mb[0] ^ md[1] ^ m9[2] ^ me[3]};
         end else begin
            o = {x2[0] ^ m3[1] ^ a[2] ^ a[3],
                 a[0] ^ x2[1] ^ m3[2] ^ a[3],
                 a[0] ^ a[1] ^ x2[2] ^ m3[3],
                 m3[0] ^ a[1] ^ a[2] ^ x2[3]};
         end
         return o;
      end
   endfunction

   function automatic logic [127:0] mix_state(input logic [127:0] s, input logic inv);
      logic [127:0] t;
      begin
         for (int c = 0; c < 4; c++)
            t[127 - 32 * c -: 32] = mix_column(s[127 - 32 * c -: 32], inv);
         return t;
      end
   endfunction

endpackage

/* rtl/aes_bcu_round.sv */
// One registered AES round stage, encrypt or decrypt per item.
`timescale 1ns / 1ps
module aes_bcu_round
   import aes_bcu_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  round_ctl_type in_ctl,
   input  logic [127:0]  in_blk,
   input  logic [127:0]  round_key,
   output logic          out_valid,
   output logic          out_dec,
   output logic [127:0]  out_blk
);

   logic         valid_ff;
   logic         dec_ff;
   logic [127:0] blk_ff;
   logic [127:0] blk_in;
   logic [127:0] s;

   always_comb begin
      s = in_blk;
      if (in_ctl.dec) begin
         s = row_shift(s, 1'b1);
         s = sub_state(s, 1'b1);
         s = s ^ round_key;
         if (in_ctl.mix_en) s = mix_state(s, 1'b1);
      end else begin
         s = sub_state(s, 1'b0);
         s = row_shift(s, 1'b0);
         if (in_ctl.mix_en) s = mix_state(s, 1'b0);
         s = s ^ round_key;
      end
      blk_in = in_ctl.active ? s : in_blk;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      dec_ff <= in_ctl.dec;
      blk_ff <= blk_in;
   end

   assign out_valid = valid_ff;
   assign out_dec   = dec_ff;
   assign out_blk   = blk_ff;

endmodule

/* rtl/aes_block_cipher_unit.sv */
// Top level of the pipelined AES-128/192/256 ECB cipher unit.
//
// Usage:
//  - Items enter on req_data with start; an item is taken at an edge where
//    start is high and busy is low. One item may enter every cycle while busy is low.
//  - Each result leaves on rsp_data with rsp_valid high for one cycle, in
//    entry order, after the key-add and the fourteen round registers. The
//    receiver cannot stall; the pipeline never holds results back.
//  - Throughput is one item per cycle while busy is low: an initial key-add
//    stage and fourteen round stages; shorter keys pass the unused tail stages unchanged.
//  - Key length and key words are written through the APB-style csr port
//    (64-bit data, register i at byte address 8*i). Any write to one of them
//    restarts the key schedule, which builds one round-key word a cycle:
//    44, 52 or 60 words for 128, 192 or 256-bit keys. busy is high then.
//  - After reset the registers are zero and the schedule for the all-zero
//    128-bit key is built, so busy stays high until that schedule is done.
//  - The user changes configuration only with the pipeline empty; the block does not enforce it.
`timescale 1ns / 1ps
module aes_block_cipher_unit
   import aes_bcu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type      req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [5:0]   paddr,
   input  logic [63:0]  pwdata,
   output logic [63:0]  prdata,
   output logic         pready
);

   `include "aes_block_cipher_unit_macros.svh"

   // configuration registers
   logic [1:0]  key_length_ff;
   logic [63:0] key_word_ff [4];
   logic [2:0]  reg_idx;
   logic        csr_write;
   logic        key_write;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[5:3];
   assign csr_write = psel && penable && pwrite && pready;
   assign key_write = csr_write && (reg_idx <= REG_KEY_WORD3);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= 2'd0;
         for (int i = 0; i < 4; i++) key_word_ff[i] <= 64'd0;
      end else if (csr_write) begin
         case (reg_idx)
            REG_KEY_LENGTH: key_length_ff  <= pwdata[1:0];
            REG_KEY_WORD0:  key_word_ff[0] <= pwdata;
            REG_KEY_WORD1:  key_word_ff[1] <= pwdata;
            REG_KEY_WORD2:  key_word_ff[2] <= pwdata;
            REG_KEY_WORD3:  key_word_ff[3] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KEY_LENGTH: prdata = {62'd0, key_length_ff};
         REG_KEY_WORD0:  prdata = key_word_ff[0];
         REG_KEY_WORD1:  prdata = key_word_ff[1];
         REG_KEY_WORD2:  prdata = key_word_ff[2];
         REG_KEY_WORD3:  prdata = key_word_ff[3];
         default:        prdata = 64'd0;
      endcase
   end

   // key size: code three behaves as 256 bits
   logic [1:0] key_sel;
   logic [3:0] nk;
   logic [3:0] nr;
   logic [5:0] last_idx;

   always_comb begin
      case (key_length_ff)
         2'd0:    key_sel = 2'd0;
         2'd1:    key_sel = 2'd1;
         default: key_sel = 2'd2;
      endcase
      nk       = 4'd4 + {1'b0, key_sel, 1'b0};
      nr       = nk + 4'(NK_TO_NR);
      last_idx = {nr, 2'b11};
   end

   // key schedule: one word a cycle over a window of the last eight words
   logic        exp_busy_ff, exp_busy_in;
   logic [5:0]  exp_idx_ff, exp_idx_in;
   logic [2:0]  exp_mod_ff, exp_mod_in;
   logic [7:0]  rcon_ff, rcon_in;
   logic [31:0] win_ff [8];
   logic [31:0] exp_word;
   logic [31:0] key_in_word;
   logic [31:0] win_back;
   logic [31:0] tmp;
   logic [31:0] rk_ff [RK_WORDS];

   always_comb begin
      key_in_word = exp_idx_ff[0] ? key_word_ff[exp_idx_ff[2:1]][31:0]
                                  : key_word_ff[exp_idx_ff[2:1]][63:32];
      case (key_sel)
         2'd0:    win_back = win_ff[3];
         2'd1:    win_back = win_ff[5];
         default: win_back = win_ff[7];
      endcase
      tmp = win_ff[0];
      if (exp_mod_ff == 3'd0) begin
         tmp = sub_key_word({tmp[23:0], tmp[31:24]}) ^ {rcon_ff, 24'd0};
      end else if ((key_sel == 2'd2) && (exp_mod_ff == 3'd4)) begin
         tmp = sub_key_word(tmp);
      end
      exp_word = (exp_idx_ff < {2'b00, nk}) ? key_in_word : (win_back ^ tmp);

      exp_busy_in = exp_busy_ff;
      exp_idx_in  = exp_idx_ff;
      exp_mod_in  = exp_mod_ff;
      rcon_in     = rcon_ff;
      if (key_write) begin
         exp_busy_in = 1'b1;
         exp_idx_in  = 6'd0;
         exp_mod_in  = 3'd0;
         rcon_in     = 8'h01;
      end else if (exp_busy_ff) begin
         exp_idx_in  = exp_idx_ff + 6'd1;
         exp_mod_in  = ({1'b0, exp_mod_ff} == nk - 4'd1) ? 3'd0 : exp_mod_ff + 3'd1;
         if ((exp_idx_ff >= {2'b00, nk}) && (exp_mod_ff == 3'd0)) rcon_in = xtime(rcon_ff);
         if (exp_idx_ff == last_idx) exp_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_busy_ff <= 1'b1;
         exp_idx_ff  <= 6'd0;
         exp_mod_ff  <= 3'd0;
         rcon_ff     <= 8'h01;
      end else begin
         exp_busy_ff <= exp_busy_in;
         exp_idx_ff  <= exp_idx_in;
         exp_mod_ff  <= exp_mod_in;
         rcon_ff     <= rcon_in;
      end
      if (exp_busy_ff && !key_write) begin
         rk_ff[exp_idx_ff] <= exp_word;
         win_ff[0] <= exp_word;
         for (int i = 1; i < 8; i++) win_ff[i] <= win_ff[i - 1];
      end
   end

   assign busy = exp_busy_ff;

   logic [127:0] rk_blk [MAX_ROUNDS + 1];

   for (genvar b = 0; b <= MAX_ROUNDS; b++) begin : g_rk
      assign rk_blk[b] = {rk_ff[4 * b], rk_ff[4 * b + 1], rk_ff[4 * b + 2], rk_ff[4 * b + 3]};
   end

   // stage 0: first key add
   logic         st_valid [MAX_ROUNDS + 1];
   logic         st_dec   [MAX_ROUNDS + 1];
   logic [127:0] st_blk   [MAX_ROUNDS + 1];
   logic         st0_valid_ff;
   logic         st0_dec_ff;
   logic [127:0] st0_blk_ff;
   logic [127:0] last_key;

   always_comb begin
      case (key_sel)
         2'd0:    last_key = rk_blk[10];
         2'd1:    last_key = rk_blk[12];
         default: last_key = rk_blk[14];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st0_valid_ff <= 1'b0;
      end else begin
         st0_valid_ff <= start && !busy;
      end
      st0_dec_ff <= req_data.command;
      st0_blk_ff <= {req_data.block_high, req_data.block_low}
                    ^ ((req_data.command == CMD_DECRYPT) ? last_key : rk_blk[0]);
   end

   assign st_valid[0] = st0_valid_ff;
   assign st_dec[0]   = st0_dec_ff;
   assign st_blk[0]   = st0_blk_ff;

   for (genvar j = 1; j <= MAX_ROUNDS; j++) begin : g_round
      localparam int K10 = (j <= 10) ? (10 - j) : 0;
      localparam int K12 = (j <= 12) ? (12 - j) : 0;
      localparam int K14 = 14 - j;
      round_ctl_type ctl;
      logic [127:0]  key_dec;
      logic [127:0]  key;

      always_comb begin
         case (key_sel)
            2'd0:    key_dec = rk_blk[K10];
            2'd1:    key_dec = rk_blk[K12];
            default: key_dec = rk_blk[K14];
         endcase
         ctl.dec    = st_dec[j - 1];
         ctl.active = (4'(j) <= nr);
         ctl.mix_en = (4'(j) < nr);
         key        = (st_dec[j - 1] == CMD_DECRYPT) ? key_dec : rk_blk[j];
      end

      aes_bcu_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[j - 1]),
         .in_ctl    (ctl),
         .in_blk    (st_blk[j - 1]),
         .round_key (key),
         .out_valid (st_valid[j]),
         .out_dec   (st_dec[j]),
         .out_blk   (st_blk[j])
      );
   end

   assign rsp_valid            = st_valid[MAX_ROUNDS];
   assign rsp_data.result_high = st_blk[MAX_ROUNDS][127:64];
   assign rsp_data.result_low  = st_blk[MAX_ROUNDS][63:0];

   `AES_ASSERT_IMPLIES(a_rsp_latency, clock, reset, rsp_valid, $past(start && !busy, 15))
   `AES_ASSERT_IMPLIES(a_exp_range, clock, reset, exp_busy_ff, exp_idx_ff <= last_idx)
   `AES_ASSERT_NEXT(a_exp_done, clock, reset,
                    exp_busy_ff && (exp_idx_ff == last_idx) && !key_write, !exp_busy_ff)

endmodule
